### rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned RemW   = 17;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;

  // Seconds per day is 675 shifted left by 7, so whole days come from a
  // reciprocal multiply of the upper 25 bits by 2**35 / 675, rounded up.
  localparam int unsigned DayShift   = 7;
  localparam int unsigned DayOddW    = 10;
  localparam int unsigned RecipW     = 26;
  localparam int unsigned RecipShift = 35;

  localparam logic [DayOddW-1:0] DayOdd      = DayOddW'(675);
  localparam logic [RecipW-1:0]  DayRecip    = RecipW'(50903317);
  localparam logic [RemW-1:0]    SecsPerHour = RemW'(3600);
  localparam logic [RemW-1:0]    SecsPerMin  = RemW'(60);
  localparam logic [YearW-1:0]   BaseYear    = YearW'(1970);
  localparam logic [1:0]         BaseMod4    = 2'd2;
  localparam logic [6:0]         BaseMod100  = 7'd70;
  localparam logic [8:0]         BaseMod400  = 9'd370;
  localparam logic [MonthW-1:0]  LastMonth   = MonthW'(11);

  typedef struct packed {
    logic load;
    logic day_step;
    logic sod_step;
    logic year_step;
    logic month_step;
    logic time_step;
    logic out_load;
  } esc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic time_done;
  } esc_sts_t;

  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/esc_stream_if.sv
// ----------------------------------------------------------------------------
// esc_stream_if
// Valid/ready channels for the seconds input and the calendar result.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, output ready);
endinterface

### rtl/core/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: day split, year walk, month walk and result hand-off.
// ----------------------------------------------------------------------------
module esc_ctrl import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  esc_sts_t sts_i,
  output esc_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DAYS  = 6'b000010,
    S_SOD   = 6'b000100,
    S_YEAR  = 6'b001000,
    S_MONTH = 6'b010000,
    S_OUT   = 6'b100000
  } esc_state_e;

  esc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic can_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_load    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DAYS;
        end
      end
      S_DAYS: begin
        cmd_o.day_step = 1'b1;
        state_d        = S_SOD;
      end
      S_SOD: begin
        cmd_o.sod_step = 1'b1;
        state_d        = S_YEAR;
      end
      S_YEAR: begin
        cmd_o.year_step = 1'b1;
        cmd_o.time_step = 1'b1;
        if (sts_i.year_done) begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd_o.month_step = 1'b1;
        cmd_o.time_step  = 1'b1;
        if (sts_i.month_done && sts_i.time_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/esc_dp.sv
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: reciprocal multiply by seconds per day, year and month walkers,
// time-of-day subtractor and the result register.
// ----------------------------------------------------------------------------
module esc_dp import esc_pkg::*; (
  input  logic               clk_i,
  input  logic [SecsW-1:0]   secs_i,
  input  esc_cmd_t           cmd_i,
  output esc_sts_t           sts_o,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o,
  output logic [HourW-1:0]   hour_o,
  output logic [MinW-1:0]    minute_o
);

  logic [SecsW-1:0]  secs_q, secs_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DaysW-1:0]  days_q, days_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [1:0]        mod4_q, mod4_d;
  logic [6:0]        mod100_q, mod100_d;
  logic [8:0]        mod400_q, mod400_d;
  logic [MonthW-1:0] mon_q, mon_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;

  logic [YearW-1:0]  res_year_q;
  logic [MonthW-1:0] res_month_q;
  logic [DayW-1:0]   res_day_q;
  logic [HourW-1:0]  res_hour_q;
  logic [MinW-1:0]   res_min_q;

  logic [SecsW-DayShift+RecipW-1:0] recip_prod;
  logic [DaysW+DayOddW-1:0]         day_base;
  logic [DaysW+DayOddW-1:0]         sod_hi;
  logic              leap;
  logic [8:0]        year_len;
  logic [DayW-1:0]   mon_len;

  assign recip_prod = secs_q[SecsW-1:DayShift] * DayRecip;
  assign day_base   = days_q * DayOdd;
  assign sod_hi     = (DaysW + DayOddW)'(secs_q[SecsW-1:DayShift]) - day_base;
  assign leap     = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = month_days(mon_q, leap);

  assign sts_o.year_done  = (days_q < DaysW'(year_len));
  assign sts_o.month_done = (mon_q == LastMonth) || (days_q < DaysW'(mon_len));
  assign sts_o.time_done  = (rem_q < SecsPerMin);

  always_comb begin
    secs_d   = secs_q;
    rem_d    = rem_q;
    days_d   = days_q;
    year_d   = year_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    mon_d    = mon_q;
    hour_d   = hour_q;
    min_d    = min_q;
    if (cmd_i.load) begin
      secs_d   = secs_i;
      year_d   = BaseYear;
      mod4_d   = BaseMod4;
      mod100_d = BaseMod100;
      mod400_d = BaseMod400;
      mon_d    = '0;
      hour_d   = '0;
      min_d    = '0;
    end
    if (cmd_i.day_step) begin
      days_d = recip_prod[RecipShift +: DaysW];
    end
    if (cmd_i.sod_step) begin
      rem_d = {sod_hi[DayOddW-1:0], secs_q[DayShift-1:0]};
    end
    if (cmd_i.year_step && !sts_o.year_done) begin
      days_d   = days_q - DaysW'(year_len);
      year_d   = year_q + 1'b1;
      mod4_d   = mod4_q + 1'b1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 1'b1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 1'b1;
    end
    if (cmd_i.month_step && !sts_o.month_done) begin
      days_d = days_q - DaysW'(mon_len);
      mon_d  = mon_q + 1'b1;
    end
    if (cmd_i.time_step && !sts_o.time_done) begin
      if (rem_q >= SecsPerHour) begin
        rem_d  = rem_q - SecsPerHour;
        hour_d = hour_q + 1'b1;
      end else begin
        rem_d = rem_q - SecsPerMin;
        min_d = min_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q   <= secs_d;
    rem_q    <= rem_d;
    days_q   <= days_d;
    year_q   <= year_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    mon_q    <= mon_d;
    hour_q   <= hour_d;
    min_q    <= min_d;
    if (cmd_i.out_load) begin
      res_year_q  <= year_q;
      res_month_q <= mon_q + 1'b1;
      res_day_q   <= days_q[DayW-1:0] + 1'b1;
      res_hour_q  <= hour_q;
      res_min_q   <= min_q;
    end
  end

  assign year_o   = res_year_q;
  assign month_o  = res_month_q;
  assign day_o    = res_day_q;
  assign hour_o   = res_hour_q;
  assign minute_o = res_min_q;

endmodule

### rtl/core/epoch_seconds_to_calendar.sv
// Sequence: after the input beat, whole days and then the seconds of the day are
// split off, followed by the year walk (one year per cycle, up to 136 steps)
// and the month walk (up to 11 steps); hours and minutes are counted alongside.
// Throughput: one item at a time; a new beat is taken once the previous result
// sits in the output register, even while that result is still stalled.
// Reset: rst_ni is asynchronous, active low; it clears the sequencer and the
// output valid flag.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts unsigned epoch seconds to Gregorian year, month, day, hour, minute.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);

  esc_cmd_t cmd;
  esc_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esc_dp u_dp (
    .clk_i    (clk_i),
    .secs_i   (in_i.epoch_seconds),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .year_o   (out_o.year),
    .month_o  (out_o.month),
    .day_o    (out_o.day_of_month),
    .hour_o   (out_o.hour),
    .minute_o (out_o.minute)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

### rtl/core/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
module esc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] year_i,
  input logic [3:0]  month_i,
  input logic [4:0]  day_i,
  input logic [4:0]  hour_i,
  input logic [5:0]  minute_i
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("Input taken again right after a beat.");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("Result dropped while stalled.");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (month_i >= 4'd1 && month_i <= 4'd12 && day_i >= 5'd1 &&
                     hour_i <= 5'd23 && minute_i <= 6'd59))
    else $error("Result field out of range.");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (year_i >= 12'd1970 && year_i <= 12'd2106))
    else $error("Year out of range.");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .year_i      (out_o.year),
  .month_i     (out_o.month),
  .day_i       (out_o.day_of_month),
  .hour_i      (out_o.hour),
  .minute_i    (out_o.minute)
);
